// ----- rtl/dqs_pkg.sv -----
`timescale 1ns / 1ps

package dqs_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // fixed field widths of the channels
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [STAT_W-1:0]  stat_t;
  typedef logic [OCC_W-1:0]   occ_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W:0]     sum_t;

  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_SEARCH     = 3'd4;

  localparam stat_t ST_DONE  = 2'd0;
  localparam stat_t ST_FULL  = 2'd1;
  localparam stat_t ST_EMPTY = 2'd2;

  typedef struct packed {
    logic  found;
    stat_t status;
    occ_t  occupancy;
  } res_t;

endpackage

// ----- rtl/dqs_cmd_if.sv -----
`timescale 1ns / 1ps

interface dqs_cmd_if;
  logic          valid;
  logic          ready;
  dqs_pkg::cmd_t   cmd;
  dqs_pkg::value_t value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ----- rtl/dqs_res_if.sv -----
`timescale 1ns / 1ps

interface dqs_res_if;
  logic          valid;
  logic          ready;
  logic          found;
  dqs_pkg::stat_t status;
  dqs_pkg::occ_t  occupancy;

  modport source (output valid, output found, output status, output occupancy, input ready);
  modport sink   (input valid, input found, input status, input occupancy, output ready);
endinterface

// ----- rtl/dqs_ram.sv -----
`timescale 1ns / 1ps

// simple dual-port RAM, registered read
module dqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/double_ended_queue_with_search.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// req       in   valid/ready    cmd[2:0], value[31:0]
// rsp       out  valid/ready    found, status[1:0], occupancy[4:0]
//
// Push, pop and unused codes form their result at accept. A search of an empty
// store answers at accept too; otherwise entries are compared from the front,
// one entry per cycle through the RAM read port, until a hit or the back entry.
// Synchronous rst clears front index, count and handshake state, not the RAM.
// A spare result slot lets an item in while the previous result waits;
// req.ready drops while that slot is full or a search scan is running.
module double_ended_queue_with_search (
  input  logic clk,
  input  logic rst,
  dqs_cmd_if.sink   req,
  dqs_res_if.source rsp
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  // ring index helpers, DEPTH need not be a power of two
  function automatic dqs_pkg::idx_t idx_inc(input dqs_pkg::idx_t i);
    if (i == dqs_pkg::idx_t'(dqs_pkg::DEPTH - 1)) begin
      return '0;
    end
    return i + dqs_pkg::idx_t'(1);
  endfunction

  function automatic dqs_pkg::idx_t idx_dec(input dqs_pkg::idx_t i);
    if (i == '0) begin
      return dqs_pkg::idx_t'(dqs_pkg::DEPTH - 1);
    end
    return i - dqs_pkg::idx_t'(1);
  endfunction

  logic           state, state_next;
  dqs_pkg::idx_t  front, front_next;
  dqs_pkg::cnt_t  count, count_next;
  dqs_pkg::idx_t  scan, scan_next;   // ring position under compare
  dqs_pkg::cnt_t  left, left_next;   // entries still to compare after scan
  dqs_pkg::data_t key, key_next;

  dqs_pkg::res_t  out_q, pend_q, res;
  logic           out_valid, pend_valid, res_valid;

  logic           ram_we;
  dqs_pkg::idx_t  ram_waddr, ram_raddr;
  dqs_pkg::data_t ram_wdata, ram_rdata;

  dqs_pkg::data_t in_data;
  dqs_pkg::sum_t  back_sum;
  dqs_pkg::idx_t  back_pos;
  logic           accept, is_full, is_empty, hit;

  assign req.ready = (state == ST_IDLE) && !pend_valid;
  assign accept    = req.valid && req.ready;
  assign in_data   = dqs_pkg::data_t'(req.value);
  assign is_full   = (count == dqs_pkg::cnt_t'(dqs_pkg::DEPTH));
  assign is_empty  = (count == '0);
  assign hit       = (ram_rdata == key);

  // slot just past the back element
  assign back_sum = dqs_pkg::sum_t'(front) + dqs_pkg::sum_t'(count);
  assign back_pos = (back_sum >= dqs_pkg::sum_t'(dqs_pkg::DEPTH)) ?
                    dqs_pkg::idx_t'(back_sum - dqs_pkg::sum_t'(dqs_pkg::DEPTH)) :
                    dqs_pkg::idx_t'(back_sum);

  dqs_ram #(
    .WIDTH (dqs_pkg::DATA_W),
    .DEPTH (dqs_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    scan_next  = scan;
    left_next  = left;
    key_next   = key;
    ram_we     = 1'b0;
    ram_waddr  = back_pos;
    ram_wdata  = in_data;
    ram_raddr  = front;
    res_valid  = 1'b0;
    res        = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_valid = 1'b1;
          unique case (req.cmd)
            dqs_pkg::CMD_PUSH_FRONT: begin
              if (is_full) begin
                res.status = dqs_pkg::ST_FULL;
              end else begin
                front_next = idx_dec(front);
                ram_we     = 1'b1;
                ram_waddr  = idx_dec(front);
                count_next = count + dqs_pkg::cnt_t'(1);
              end
            end
            dqs_pkg::CMD_PUSH_BACK: begin
              if (is_full) begin
                res.status = dqs_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                count_next = count + dqs_pkg::cnt_t'(1);
              end
            end
            dqs_pkg::CMD_POP_FRONT: begin
              if (is_empty) begin
                res.status = dqs_pkg::ST_EMPTY;
              end else begin
                front_next = idx_inc(front);
                count_next = count - dqs_pkg::cnt_t'(1);
              end
            end
            dqs_pkg::CMD_POP_BACK: begin
              if (is_empty) begin
                res.status = dqs_pkg::ST_EMPTY;
              end else begin
                count_next = count - dqs_pkg::cnt_t'(1);
              end
            end
            dqs_pkg::CMD_SEARCH: begin
              // empty list answers at once; otherwise start the scan at front
              if (!is_empty) begin
                res_valid  = 1'b0;
                state_next = ST_SEARCH;
                key_next   = in_data;
                scan_next  = front;
                left_next  = count - dqs_pkg::cnt_t'(1);
                ram_raddr  = front;
              end
            end
            default: begin
            end
          endcase
          res.occupancy = dqs_pkg::occ_t'(count_next);
        end
      end
      ST_SEARCH: begin
        res.occupancy = dqs_pkg::occ_t'(count);
        if (hit || left == '0) begin
          res_valid  = 1'b1;
          res.found  = hit;
          state_next = ST_IDLE;
        end else begin
          scan_next = idx_inc(scan);
          left_next = left - dqs_pkg::cnt_t'(1);
          ram_raddr = idx_inc(scan);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
    scan <= scan_next;
    left <= left_next;
    key  <= key_next;
  end

  // result register with one spare slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      if (pend_valid) begin
        out_q      <= pend_q;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (res_valid) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (res_valid) begin
      pend_q     <= res;
      pend_valid <= 1'b1;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.found     = out_q.found;
  assign rsp.status    = out_q.status;
  assign rsp.occupancy = out_q.occupancy;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

  // cycles with no item moving on either channel before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 400;
  // first command code past the defined ones; codes from here up are ignored
  localparam int CMD_SPARE_FIRST = dqs_pkg::CMD_SEARCH + 1;
  localparam int CMD_SPARE_LAST  = (1 << dqs_pkg::CMD_W) - 1;

  // traffic mix of the random part
  localparam int MIX_GROW   = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_EVEN   = 2;

  // Ring-store model of the deque plus the queue of results still owed.
  class deque_scoreboard;
    dqs_pkg::data_t ring [dqs_pkg::DEPTH];
    int             head;
    int             held;
    dqs_pkg::res_t  owed_q [$];
    int unsigned    errors;

    function new();
      head   = 0;
      held   = 0;
      errors = 0;
    endfunction

    // Apply one accepted command to the model and queue its result.
    function void note_cmd(dqs_pkg::cmd_t c, dqs_pkg::value_t v);
      dqs_pkg::res_t  r;
      dqs_pkg::data_t d;
      d = dqs_pkg::data_t'(v);
      r.found  = 1'b0;
      r.status = dqs_pkg::ST_DONE;
      case (c)
        dqs_pkg::CMD_PUSH_FRONT: begin
          if (held >= dqs_pkg::DEPTH) begin
            r.status = dqs_pkg::ST_FULL;
          end else begin
            head = (head + dqs_pkg::DEPTH - 1) % dqs_pkg::DEPTH;
            ring[head] = d;
            held++;
          end
        end
        dqs_pkg::CMD_PUSH_BACK: begin
          if (held >= dqs_pkg::DEPTH) begin
            r.status = dqs_pkg::ST_FULL;
          end else begin
            ring[(head + held) % dqs_pkg::DEPTH] = d;
            held++;
          end
        end
        dqs_pkg::CMD_POP_FRONT: begin
          if (held == 0) begin
            r.status = dqs_pkg::ST_EMPTY;
          end else begin
            head = (head + 1) % dqs_pkg::DEPTH;
            held--;
          end
        end
        dqs_pkg::CMD_POP_BACK: begin
          if (held == 0) r.status = dqs_pkg::ST_EMPTY;
          else held--;
        end
        dqs_pkg::CMD_SEARCH: begin
          // every held entry, back one included
          for (int i = 0; i < held; i++)
            if (ring[(head + i) % dqs_pkg::DEPTH] == d) r.found = 1'b1;
        end
        default: ;
      endcase
      r.occupancy = dqs_pkg::occ_t'(held);
      owed_q.push_back(r);
    endfunction

    function void check_result(logic f, dqs_pkg::stat_t s, dqs_pkg::occ_t o);
      dqs_pkg::res_t w;
      if (owed_q.size() == 0) begin
        $display("%0t: result with none owed: found %0d status %0d occupancy %0d",
                 $time, f, s, o);
        errors++;
        return;
      end
      w = owed_q.pop_front();
      if (f !== w.found) begin
        $display("%0t: found: expected %0d, actual %0d", $time, w.found, f);
        errors++;
      end
      if (s !== w.status) begin
        $display("%0t: status: expected %0d, actual %0d", $time, w.status, s);
        errors++;
      end
      if (o !== w.occupancy) begin
        $display("%0t: occupancy: expected %0d, actual %0d", $time, w.occupancy, o);
        errors++;
      end
    endfunction

    // A word currently held, so searches hit; random when empty.
    function dqs_pkg::value_t held_value();
      if (held == 0) return $urandom();
      return dqs_pkg::value_t'(ring[(head + $urandom_range(held - 1)) % dqs_pkg::DEPTH]);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   idle_pct;   // chance in 100 that the sender holds off a cycle
  int   stall_pct;  // chance in 100 that the receiver is not ready
  int   quiet_cycles;

  deque_scoreboard sb;

  dqs_cmd_if req_ch ();
  dqs_res_if rsp_ch ();

  double_ended_queue_with_search uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Receiver: ready is redrawn every cycle from the current stall rate.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Both channels observed in one process: the command is noted before the
  // result of the same edge is checked, so ordering never depends on the
  // scheduler. The watchdog runs here too.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) sb.note_cmd(req_ch.cmd, req_ch.value);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.found, rsp_ch.status, rsp_ch.occupancy);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Offer one command and hold it until the block takes it. valid stays up
  // between back-to-back items; it only drops when a gap is drawn or on drain.
  task automatic send_cmd(input dqs_pkg::cmd_t c, input dqs_pkg::value_t v);
    if ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= c;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Sender goes quiet until every owed result has been taken. The first edge
  // lets the monitor note the item accepted just before.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One random command. The mix steers the fill level so that runs reach
  // both full and empty; searches mostly look for a word that is held.
  task automatic random_cmd(input int mix);
    int              r;
    int              push_pct;
    int              pop_pct;
    dqs_pkg::value_t v;
    dqs_pkg::cmd_t   c;
    r = $urandom_range(99);
    v = ($urandom_range(3) == 0) ? dqs_pkg::value_t'($urandom_range(7)) :
                                   dqs_pkg::value_t'($urandom());
    case (mix)
      MIX_GROW:   begin push_pct = 65; pop_pct = 10; end
      MIX_SHRINK: begin push_pct = 10; pop_pct = 65; end
      default:    begin push_pct = 35; pop_pct = 35; end
    endcase
    if (r < push_pct) begin
      c = $urandom_range(1) ? dqs_pkg::CMD_PUSH_BACK : dqs_pkg::CMD_PUSH_FRONT;
    end else if (r < push_pct + pop_pct) begin
      c = $urandom_range(1) ? dqs_pkg::CMD_POP_BACK : dqs_pkg::CMD_POP_FRONT;
    end else if (r < 96) begin
      c = dqs_pkg::CMD_SEARCH;
      if ($urandom_range(9) < 6) v = sb.held_value();
    end else begin
      c = dqs_pkg::cmd_t'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    end
    send_cmd(c, v);
  endtask

  initial begin
    int mix;
    sb = new();
    idle_pct  = 0;
    stall_pct = 0;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.cmd   <= dqs_pkg::CMD_PUSH_FRONT;
    req_ch.value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty corner cases first.
    send_cmd(dqs_pkg::CMD_SEARCH, '0);
    send_cmd(dqs_pkg::CMD_POP_FRONT, '1);
    send_cmd(dqs_pkg::CMD_POP_BACK, '0);
    // extremes of the data word, hit and miss searches
    send_cmd(dqs_pkg::CMD_PUSH_FRONT, '0);
    send_cmd(dqs_pkg::CMD_PUSH_BACK, '1);
    send_cmd(dqs_pkg::CMD_SEARCH, '0);
    send_cmd(dqs_pkg::CMD_SEARCH, '1);
    send_cmd(dqs_pkg::CMD_SEARCH, 32'h5555_aaaa);
    // fill to capacity, then pushes on a full store are dropped
    for (int i = 2; i < dqs_pkg::DEPTH; i++)
      send_cmd(dqs_pkg::CMD_PUSH_BACK, dqs_pkg::value_t'(32'h8000_0000 + i));
    send_cmd(dqs_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
    send_cmd(dqs_pkg::CMD_PUSH_BACK, 32'h1234_5678);
    // the back entry must be examined too
    send_cmd(dqs_pkg::CMD_SEARCH, dqs_pkg::value_t'(32'h8000_0000 + dqs_pkg::DEPTH - 1));
    // unused codes leave everything alone
    for (int k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++)
      send_cmd(dqs_pkg::cmd_t'(k), '1);
    drain();

    // Random: four handshake phases, each ending with a full drain.
    mix = MIX_EVEN;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 78; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 7;  stall_pct = 7;  end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 24 == 0) mix = $urandom_range(MIX_EVEN, MIX_GROW);
        random_cmd(mix);
      end
      drain();
    end

    // Settle: catch any stray result after the last one owed.
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
